>>> rtl/pee_pkg.sv
// ----------------------------------------------------------------------------
// pee_pkg: shared types and codes
// Item kinds, character classes, operator and error codes of the evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

  localparam int NUM_VARS = 26;

  // input operation field
  localparam logic [1:0] OPN_CHAR = 2'd0;
  localparam logic [1:0] OPN_LOAD = 2'd1;
  localparam logic [1:0] OPN_END  = 2'd2;
  localparam logic [1:0] OPN_RSVD = 2'd3;

  // character classes
  localparam logic [2:0] CL_OTHER  = 3'd0;
  localparam logic [2:0] CL_DIGIT  = 3'd1;
  localparam logic [2:0] CL_SPACE  = 3'd2;
  localparam logic [2:0] CL_OPER   = 3'd3;
  localparam logic [2:0] CL_MINUS  = 3'd4;
  localparam logic [2:0] CL_LETTER = 3'd5;

  // operator codes
  localparam logic [2:0] OPC_ADD = 3'd0;
  localparam logic [2:0] OPC_SUB = 3'd1;
  localparam logic [2:0] OPC_MUL = 3'd2;
  localparam logic [2:0] OPC_DIV = 3'd3;
  localparam logic [2:0] OPC_LT  = 3'd4;
  localparam logic [2:0] OPC_EQ  = 3'd5;
  localparam logic [2:0] OPC_SEL = 3'd6;

  // error codes
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_UNDER = 3'd1;
  localparam logic [2:0] ERR_OVER  = 3'd2;
  localparam logic [2:0] ERR_DIVZ  = 3'd3;
  localparam logic [2:0] ERR_EMPTY = 3'd4;

  // ASCII
  localparam logic [7:0] CH_0     = 8'd48;
  localparam logic [7:0] CH_9     = 8'd57;
  localparam logic [7:0] CH_A     = 8'd97;
  localparam logic [7:0] CH_Z     = 8'd122;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_LT    = 8'd60;
  localparam logic [7:0] CH_EQ    = 8'd61;
  localparam logic [7:0] CH_QUEST = 8'd63;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  cls;
    logic [2:0]  opc;
    logic [3:0]  digit;
    logic [4:0]  var_index;
    logic [31:0] var_value;
  } item_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } alu_req_t;

endpackage

>>> rtl/pee_front.sv
// ----------------------------------------------------------------------------
// pee_front: input decode and queue
// Accepts input items, classifies characters, queues them for the back end.
// ----------------------------------------------------------------------------
module pee_front import pee_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [7:0]  symbol,
  input  logic [4:0]  var_index,
  input  logic [31:0] var_value,
  output logic        q_valid,
  input  logic        q_ready,
  output item_t       q_item
);

  item_t      q_mem_r [2];
  logic       wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  item_t      cls_item;

  function automatic item_t classify(input logic [1:0] op, input logic [7:0] c,
                                     input logic [4:0] idx, input logic [31:0] val);
    item_t it;
    logic [7:0] li;
    it = '0;
    li = c - CH_A;
    it.kind = op;
    it.var_index = idx;
    it.var_value = val;
    it.digit = c[3:0];
    it.cls = CL_OTHER;
    it.opc = OPC_ADD;
    if (c >= CH_0 && c <= CH_9) begin
      it.cls = CL_DIGIT;
    end else if (c >= CH_A && c <= CH_Z) begin
      it.cls = CL_LETTER;
      if (op == OPN_CHAR) it.var_index = li[4:0];
    end else begin
      case (c)
        CH_SPACE: it.cls = CL_SPACE;
        CH_MINUS: it.cls = CL_MINUS;
        CH_PLUS:  begin it.cls = CL_OPER; it.opc = OPC_ADD; end
        CH_STAR:  begin it.cls = CL_OPER; it.opc = OPC_MUL; end
        CH_SLASH: begin it.cls = CL_OPER; it.opc = OPC_DIV; end
        CH_LT:    begin it.cls = CL_OPER; it.opc = OPC_LT;  end
        CH_EQ:    begin it.cls = CL_OPER; it.opc = OPC_EQ;  end
        CH_QUEST: begin it.cls = CL_OPER; it.opc = OPC_SEL; end
        default:  it.cls = CL_OTHER;
      endcase
    end
    return it;
  endfunction

  assign cls_item = classify(operation, symbol, var_index, var_value);
  assign in_ready = (cnt_r != 2'd2);
  // operation code 3 is taken and dropped here
  assign push     = in_valid && in_ready && (operation != OPN_RSVD);
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = q_mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_r] <= cls_item;
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/pee_alu.sv
// ----------------------------------------------------------------------------
// pee_alu: iterative multiply / divide
// Shift-add multiply and restoring signed divide, one bit per cycle.
// ----------------------------------------------------------------------------
module pee_alu import pee_pkg::*; #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  alu_req_t      req,
  input  logic [DW-1:0] opa,
  input  logic [DW-1:0] opb,
  output logic          done,
  output logic [DW-1:0] res
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt, done_r, done_nxt, div_r, div_nxt, neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] x_r, x_nxt, y_r, y_nxt, acc_r, acc_nxt;
  logic [DW:0]   rem_sh;
  logic [DW-1:0] mag_a, mag_b;

  assign mag_a  = opa[DW-1] ? -opa : opa;
  assign mag_b  = opb[DW-1] ? -opb : opb;
  assign rem_sh = {acc_r, x_r[DW-1]};
  assign done   = done_r;
  assign res    = div_r ? (neg_r ? -x_r : x_r) : acc_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      div_nxt  = req.is_div;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      neg_nxt  = opa[DW-1] ^ opb[DW-1];
      x_nxt    = req.is_div ? mag_a : opa;
      y_nxt    = req.is_div ? mag_b : opb;
    end else if (busy_r) begin
      if (div_r) begin
        x_nxt = {x_r[DW-2:0], 1'b0};
        if (rem_sh >= {1'b0, y_r}) begin
          acc_nxt  = rem_sh[DW-1:0] - y_r;
          x_nxt[0] = 1'b1;
        end else begin
          acc_nxt = rem_sh[DW-1:0];
        end
      end else begin
        if (y_r[0]) acc_nxt = acc_r + x_r;
        x_nxt = {x_r[DW-2:0], 1'b0};
        y_nxt = {1'b0, y_r[DW-1:1]};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

>>> rtl/pee_back.sv
// ----------------------------------------------------------------------------
// pee_back: evaluation sequencer
// Runs each queued item against the operand stack, variables and result reg.
// ----------------------------------------------------------------------------
module pee_back import pee_pkg::*; #(
  parameter int STACK_DEPTH = 64,
  parameter int DW          = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_value,
  output logic [2:0]  out_err
);

  localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SP_W = $clog2(STACK_DEPTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PM   = 4'd1;
  localparam logic [3:0] S_CDIG = 4'd2;
  localparam logic [3:0] S_DISP = 4'd3;
  localparam logic [3:0] S_RD0  = 4'd4;
  localparam logic [3:0] S_RD1  = 4'd5;
  localparam logic [3:0] S_RD2  = 4'd6;
  localparam logic [3:0] S_RD3  = 4'd7;
  localparam logic [3:0] S_EXE  = 4'd8;
  localparam logic [3:0] S_ALU  = 4'd9;
  localparam logic [3:0] S_PUSH = 4'd10;
  localparam logic [3:0] S_EFIN = 4'd11;
  localparam logic [3:0] S_EPM  = 4'd12;
  localparam logic [3:0] S_ETOP = 4'd13;
  localparam logic [3:0] S_ERD  = 4'd14;

  logic [3:0]      state_r, state_nxt, ret_r, ret_nxt;
  item_t           cur_r, cur_nxt;
  logic [2:0]      opc_r, opc_nxt, err_r, err_nxt;
  logic [SP_W-1:0] sp_r, sp_nxt, sp_m1, sp_m2, sp_m3;
  logic [DW-1:0]   acc_r, acc_nxt, a_r, a_nxt, b_r, b_nxt, res_r, res_nxt;
  logic            in_num_r, in_num_nxt, pm_r, pm_nxt, neg_r, neg_nxt;
  logic            out_vld_r, out_vld_nxt;
  logic [31:0]     out_val_r, out_val_nxt;
  logic [2:0]      out_err_r, out_err_nxt;
  logic [DW-1:0]   mem [STACK_DEPTH];
  logic [DW-1:0]   rdata_r;
  logic [AW-1:0]   mem_ra, mem_wa;
  logic            mem_we;
  logic [DW-1:0]   var_r [NUM_VARS];
  logic            var_vld_r [NUM_VARS];
  logic            var_we;
  logic [DW-1:0]   var_rd, num_val;
  logic            flag_v, out_free;
  logic [2:0]      flag_code;
  alu_req_t        alu_req;
  logic            alu_done;
  logic [DW-1:0]   alu_res;

  pee_alu #(.DW(DW)) u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (alu_req),
    .opa  (a_r),
    .opb  (b_r),
    .done (alu_done),
    .res  (alu_res)
  );

  assign sp_m1   = sp_r - SP_W'(1);
  assign sp_m2   = sp_r - SP_W'(2);
  assign sp_m3   = sp_r - SP_W'(3);
  assign mem_wa  = sp_r[AW-1:0];
  assign var_rd  = var_vld_r[cur_r.var_index] ? var_r[cur_r.var_index] : '0;
  assign num_val = neg_r ? -acc_r : acc_r;
  assign out_free  = !out_vld_r || out_ready;
  assign q_ready   = (state_r == S_IDLE);
  assign out_valid = out_vld_r;
  assign out_value = out_val_r;
  assign out_err   = out_err_r;

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    cur_nxt     = cur_r;
    opc_nxt     = opc_r;
    err_nxt     = err_r;
    sp_nxt      = sp_r;
    acc_nxt     = acc_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    res_nxt     = res_r;
    in_num_nxt  = in_num_r;
    pm_nxt      = pm_r;
    neg_nxt     = neg_r;
    out_vld_nxt = (out_vld_r && out_ready) ? 1'b0 : out_vld_r;
    out_val_nxt = out_val_r;
    out_err_nxt = out_err_r;
    mem_ra      = sp_m1[AW-1:0];
    mem_we      = 1'b0;
    var_we      = 1'b0;
    flag_v      = 1'b0;
    flag_code   = ERR_NONE;
    alu_req     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          cur_nxt = q_item;
          case (q_item.kind)
            OPN_LOAD: var_we = (q_item.var_index < 5'(NUM_VARS));
            OPN_CHAR: state_nxt = S_PM;
            OPN_END:  state_nxt = S_EFIN;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_PM: begin
        state_nxt = S_CDIG;
        if (pm_r) begin
          pm_nxt = 1'b0;
          if (cur_r.cls == CL_SPACE) begin
            opc_nxt   = OPC_SUB;
            ret_nxt   = S_CDIG;
            state_nxt = S_RD0;
          end else begin
            neg_nxt = 1'b1;
          end
        end
      end
      S_CDIG: begin
        if (cur_r.cls == CL_DIGIT) begin
          acc_nxt    = in_num_r ? (acc_r << 3) + (acc_r << 1) + DW'(cur_r.digit)
                                : DW'(cur_r.digit);
          in_num_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else if (in_num_r) begin
          res_nxt    = num_val;
          neg_nxt    = 1'b0;
          in_num_nxt = 1'b0;
          acc_nxt    = '0;
          ret_nxt    = S_DISP;
          state_nxt  = S_PUSH;
        end else begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_IDLE;
        case (cur_r.cls)
          CL_OPER: begin
            opc_nxt   = cur_r.opc;
            ret_nxt   = S_IDLE;
            state_nxt = S_RD0;
          end
          CL_MINUS: pm_nxt = 1'b1;
          CL_LETTER: begin
            res_nxt   = var_rd;
            ret_nxt   = S_IDLE;
            state_nxt = S_PUSH;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_RD0: begin
        // underflow leaves the stack as it is
        if (sp_r < ((opc_r == OPC_SEL) ? SP_W'(3) : SP_W'(2))) begin
          flag_v    = 1'b1;
          flag_code = ERR_UNDER;
          state_nxt = ret_r;
        end else begin
          mem_ra    = sp_m1[AW-1:0];
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        b_nxt     = rdata_r;
        mem_ra    = sp_m2[AW-1:0];
        state_nxt = S_RD2;
      end
      S_RD2: begin
        a_nxt     = rdata_r;
        mem_ra    = sp_m3[AW-1:0];
        state_nxt = (opc_r == OPC_SEL) ? S_RD3 : S_EXE;
      end
      S_RD3: begin
        res_nxt   = (rdata_r != '0) ? a_r : b_r;
        sp_nxt    = sp_m3;
        state_nxt = S_PUSH;
      end
      S_EXE: begin
        sp_nxt    = sp_m2;
        state_nxt = S_PUSH;
        case (opc_r)
          OPC_SUB: res_nxt = a_r - b_r;
          OPC_LT:  res_nxt = DW'($signed(a_r) < $signed(b_r));
          OPC_EQ:  res_nxt = DW'(a_r == b_r);
          OPC_MUL: begin
            alu_req.start = 1'b1;
            state_nxt     = S_ALU;
          end
          OPC_DIV: begin
            if (b_r == '0) begin
              flag_v    = 1'b1;
              flag_code = ERR_DIVZ;
              res_nxt   = '0;
            end else begin
              alu_req.start  = 1'b1;
              alu_req.is_div = 1'b1;
              state_nxt      = S_ALU;
            end
          end
          default: res_nxt = a_r + b_r;
        endcase
      end
      S_ALU: begin
        if (alu_done) begin
          res_nxt   = alu_res;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (sp_r >= SP_W'(STACK_DEPTH)) begin
          flag_v    = 1'b1;
          flag_code = ERR_OVER;
        end else begin
          mem_we = 1'b1;
          sp_nxt = sp_r + SP_W'(1);
        end
        state_nxt = ret_r;
      end
      S_EFIN: begin
        if (in_num_r) begin
          res_nxt    = num_val;
          neg_nxt    = 1'b0;
          in_num_nxt = 1'b0;
          acc_nxt    = '0;
          ret_nxt    = S_EPM;
          state_nxt  = S_PUSH;
        end else begin
          state_nxt = S_EPM;
        end
      end
      S_EPM: begin
        state_nxt = S_ETOP;
        if (pm_r) begin
          pm_nxt    = 1'b0;
          opc_nxt   = OPC_SUB;
          ret_nxt   = S_ETOP;
          state_nxt = S_RD0;
        end
      end
      S_ETOP: begin
        if (err_r != ERR_NONE || sp_r == '0) begin
          if (out_free) begin
            out_vld_nxt = 1'b1;
            out_val_nxt = '0;
            out_err_nxt = (err_r != ERR_NONE) ? err_r : ERR_EMPTY;
            sp_nxt      = '0;
            err_nxt     = ERR_NONE;
            in_num_nxt  = 1'b0;
            acc_nxt     = '0;
            state_nxt   = S_IDLE;
          end
        end else begin
          state_nxt = S_ERD;
        end
      end
      S_ERD: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          out_val_nxt = 32'(rdata_r);
          out_err_nxt = ERR_NONE;
          sp_nxt      = '0;
          in_num_nxt  = 1'b0;
          acc_nxt     = '0;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // first error of an expression wins
    if (flag_v && err_r == ERR_NONE) err_nxt = flag_code;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= res_r;
    rdata_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (var_we) var_r[cur_nxt.var_index] <= DW'($signed(cur_nxt.var_value));
    for (int i = 0; i < NUM_VARS; i++) begin
      if (!rst_n) var_vld_r[i] <= 1'b0;
      else if (var_we && cur_nxt.var_index == 5'(i)) var_vld_r[i] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    opc_r     <= opc_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    res_r     <= res_nxt;
    ret_r     <= ret_nxt;
    out_val_r <= out_val_nxt;
    out_err_r <= out_err_nxt;
    if (!rst_n) begin
      state_r   <= S_IDLE;
      err_r     <= ERR_NONE;
      sp_r      <= '0;
      acc_r     <= '0;
      in_num_r  <= 1'b0;
      pm_r      <= 1'b0;
      neg_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      err_r     <= err_nxt;
      sp_r      <= sp_nxt;
      acc_r     <= acc_nxt;
      in_num_r  <= in_num_nxt;
      pm_r      <= pm_nxt;
      neg_r     <= neg_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

>>> rtl/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator: postfix expression engine
// Evaluates a character stream of postfix expressions over an operand stack.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                     | tuser
//  in_     | in  | symbol, var_index, value  | operation (char/load/end)
//  out_    | out | result_value              | error_code
//
// Flow: an operator does two or three stack reads through the single memory
// port plus a push; * and / go through the bit-serial unit. Closing a literal
// adds one push.
// Reset: synchronous active-low; stack empty, variables read as zero.
// Stalls: a 2-item queue sits in front of the sequencer; the result register
// frees the sequencer as soon as the result is written to it.
module postfix_expression_evaluator import pee_pkg::*; #(
  parameter int STACK_DEPTH = 64,
  parameter int DATA_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [7:0] symbol, [12:8] var_index, [44:13] var_value
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_value
  output logic [2:0]  out_tuser   // [2:0] error_code
);

  logic  q_valid, q_ready;
  item_t q_item;

  // front: decode and queue
  pee_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .operation(in_tuser),
    .symbol   (in_tdata[7:0]),
    .var_index(in_tdata[12:8]),
    .var_value(in_tdata[44:13]),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  // back: stack machine
  pee_back #(.STACK_DEPTH(STACK_DEPTH), .DW(DATA_WIDTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_value(out_tdata),
    .out_err  (out_tuser)
  );

endmodule

>>> rtl/pee_chk.sv
// ----------------------------------------------------------------------------
// pee_chk: port checker
// Watches the evaluator ports for result and reset behavior.
// ----------------------------------------------------------------------------
module pee_chk import pee_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result dropped while stalled");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= ERR_EMPTY)
    else $error("bad error code");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ERR_NONE |-> out_tdata == 32'd0)
    else $error("error result not zero");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind postfix_expression_evaluator pee_chk u_pee_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: postfix expression evaluator bench
// Drives character, load and end items in directed and random expressions,
// predicts every result with a behavioral model and compares field by field.
// ----------------------------------------------------------------------------
module tb;
  import pee_pkg::*;

  localparam int DEPTH = 64;
  localparam int WDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = OPN_CHAR;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;

  always #5 clk = ~clk;

  postfix_expression_evaluator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  code;
  } answer_t;

  // model state of the evaluator
  logic [31:0] opstack [DEPTH];
  int          sp;
  logic [31:0] vars [NUM_VARS];
  logic [31:0] num_acc;
  bit          in_num, minus_wait, neg_next;
  logic [2:0]  first_err;

  answer_t answers [$];
  int      errors = 0;
  int      send_gap = 0;   // percent idle on the input side
  int      sink_stall = 0; // percent stall on the output side
  int      quiet = 0;
  int      depth_now = 0;  // model stack depth, used to steer random ops
  int      items_sent = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic void flag(input logic [2:0] c);
    if (first_err == ERR_NONE) first_err = c;
  endfunction

  function automatic void push(input logic [31:0] v);
    if (sp >= DEPTH) begin
      flag(ERR_OVER);
      return;
    end
    opstack[sp] = v;
    sp++;
  endfunction

  function automatic void apply_binary(input logic [7:0] c);
    logic [31:0] a, b, r, ma, mb;
    if (sp < 2) begin
      flag(ERR_UNDER);
      return;
    end
    b = opstack[sp-1];
    a = opstack[sp-2];
    sp -= 2;
    case (c)
      CH_PLUS:  r = a + b;
      CH_MINUS: r = a - b;
      CH_STAR:  r = a * b;
      CH_LT:    r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      CH_EQ:    r = (a == b) ? 32'd1 : 32'd0;
      default: begin
        if (b == 0) begin
          flag(ERR_DIVZ);
          r = 0;
        end else begin
          ma = a[31] ? -a : a;
          mb = b[31] ? -b : b;
          r = ma / mb;
          if (a[31] ^ b[31]) r = -r;
        end
      end
    endcase
    push(r);
  endfunction

  function automatic void close_literal();
    logic [31:0] v;
    if (!in_num) return;
    v = num_acc;
    if (neg_next) begin
      v = -v;
      neg_next = 0;
    end
    in_num = 0;
    num_acc = 0;
    push(v);
  endfunction

  function automatic void eval_char(input logic [7:0] c);
    if (minus_wait) begin
      minus_wait = 0;
      if (c != CH_SPACE) neg_next = 1;
      else apply_binary(CH_MINUS);
    end
    if (c >= CH_0 && c <= CH_9) begin
      num_acc = in_num ? num_acc * 10 + (c - CH_0) : 32'(c - CH_0);
      in_num = 1;
      return;
    end
    close_literal();
    case (c)
      CH_PLUS, CH_STAR, CH_SLASH, CH_LT, CH_EQ: apply_binary(c);
      CH_MINUS: minus_wait = 1;
      CH_QUEST: begin
        if (sp < 3) flag(ERR_UNDER);
        else begin
          sp -= 3;
          push(opstack[sp] != 0 ? opstack[sp+1] : opstack[sp+2]);
        end
      end
      default: if (c >= CH_A && c <= CH_Z) push(vars[c - CH_A]);
    endcase
  endfunction

  // returns 1 and the answer when the item ends an expression
  function automatic bit evaluate(input logic [1:0] opn, input logic [47:0] d,
                                  output answer_t ans);
    ans = '0;
    if (opn == OPN_CHAR) eval_char(d[7:0]);
    else if (opn == OPN_LOAD) begin
      if (d[12:8] < NUM_VARS) vars[d[12:8]] = d[44:13];
    end else if (opn == OPN_END) begin
      close_literal();
      if (minus_wait) begin
        minus_wait = 0;
        apply_binary(CH_MINUS);
      end
      if (first_err != ERR_NONE) ans.code = first_err;
      else if (sp == 0) ans.code = ERR_EMPTY;
      else begin
        ans.code = ERR_NONE;
        ans.value = opstack[sp-1];
      end
      sp = 0;
      first_err = ERR_NONE;
      in_num = 0;
      num_acc = 0;
    end
    depth_now = sp;
    return opn == OPN_END;
  endfunction

  // send one item; expectation is queued at the accepting edge
  // valid stays up after the accept until the next item or an idle cycle
  task automatic send_item(input logic [1:0] opn, input logic [47:0] d);
    answer_t ans;
    while ($urandom_range(99) < send_gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= opn;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (evaluate(opn, d, ans)) answers.push_back(ans);
    items_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    send_item(OPN_CHAR, {40'd0, c});
  endtask

  task automatic send_load(input logic [4:0] idx, input logic [31:0] v);
    send_item(OPN_LOAD, {3'd0, v, idx, 8'd0});
  endtask

  task automatic send_end();
    send_item(OPN_END, {3'd0, 32'($urandom), 5'($urandom), 8'($urandom)});
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_char(s[i]);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (answers.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // result checker and output stall
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (answers.size() == 0) begin
        report("unexpected result", out_tdata, 32'd0);
      end else begin
        want = answers.pop_front();
        if (out_tdata !== want.value) report("result_value", out_tdata, want.value);
        if (out_tuser !== want.code) report("error_code", 32'(out_tuser), 32'(want.code));
      end
    end
    out_tready <= ($urandom_range(99) >= sink_stall);
  end

  // watchdog on accept-free stretches
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WDOG_LIMIT) begin
      $display("postfix_expression_evaluator: mismatch");
      $finish;
    end
  end

  // extremes, each operator and the listed corner cases
  task automatic test_directed();
    send_load(5'd0, 32'h8000_0000);
    send_load(5'd25, 32'h7fff_ffff);
    send_load(5'd31, 32'h1234_5678);   // bad index, ignored
    send_text("a z + 3 4 * 7 2 / < 1 1 = ? ");
    send_end();
    send_text("a 0 1 - / ");           // most negative / -1
    send_end();
    send_text("5 0 /");                // divide by zero
    send_end();
    send_text("+");                    // underflow
    send_end();
    send_end();                        // empty stack
    send_text("9 -4 -");               // negate then trailing subtract
    send_end();
    send_text("-7");                   // negate applied when end closes the literal
    send_end();
    send_item(OPN_RSVD, 48'hffff_ffff_ffff); // unused code ignored
    send_text("99999999999 2 - ");
    send_end();
  endtask

  task automatic test_overflow();
    for (int i = 0; i < DEPTH + 2; i++) send_text("1 ");
    send_end();
  endtask

  // random expressions, not always well-formed, plus noise
  task automatic random_expr();
    int n;
    string ops = "+-*/<=";
    n = $urandom_range(1, 12);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: send_char(8'($urandom));
        1: send_load(5'($urandom), $urandom);
        2: send_char(8'($urandom_range(CH_A, CH_Z)));
        3: send_char(CH_QUEST);
        4, 5: if (depth_now >= 2) begin
          send_char(ops[$urandom_range(5)]);
          send_char(CH_SPACE);
        end else send_char(8'($urandom_range(CH_A, CH_Z)));
        default: begin
          if ($urandom_range(3) == 0) send_char(CH_MINUS);
          repeat ($urandom_range(1, 11)) send_char(8'($urandom_range(CH_0, CH_9)));
          send_char(CH_SPACE);
        end
      endcase
    end
    send_end();
  endtask

  task automatic test_random(input int items_goal);
    int start;
    start = items_sent;
    while (items_sent - start < items_goal) random_expr();
  endtask

  initial begin
    sp = 0; num_acc = 0; in_num = 0; minus_wait = 0; neg_next = 0;
    first_err = ERR_NONE;
    foreach (vars[i]) vars[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain();
    test_overflow();
    drain();                           // sender waits for every result
    test_random(260);
    send_gap = 68;
    test_random(260);
    send_gap = 0; sink_stall = 68;
    test_random(260);
    send_gap = 14; sink_stall = 14;
    test_random(260);
    drain();
    if (errors == 0 && answers.size() == 0)
      $display("postfix_expression_evaluator: match");
    else
      $display("postfix_expression_evaluator: mismatch");
    $finish;
  end

endmodule
